// File: rtl/core/xbs_pkg.sv
// Shared constants, codes and controller/datapath interface types of the sketch update block.
package xbs_pkg;

	localparam int BITMAP_WORDS = 2048;
	localparam int WORD_BITS    = 32;
	localparam int WORD_IDX_W   = $clog2(BITMAP_WORDS);
	localparam int BIT_POS_W    = $clog2(WORD_BITS);
	localparam int COUNT_W      = 17;
	localparam int ELEM_W       = 32;
	localparam int SEED_W       = 32;
	localparam int LOG2_W       = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int BIT_CAP      = 31;
	localparam int LOG2_CAP     = 16;
	localparam int L2_W         = 5;

	localparam logic [63:0] MUL_C1 = 64'h87c3_7b91_1142_53d5;
	localparam logic [63:0] MUL_C2 = 64'h4cf5_ad43_2745_937f;
	localparam logic [63:0] MIX_F1 = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] MIX_F2 = 64'hc4ce_b9fe_1a85_ec53;
	localparam logic [63:0] KEY_LEN = 64'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS_LOG2 = 2'd1;
	localparam logic [LOG2_W-1:0]    WORDS_LOG2_RESET = 4'd11;

	localparam logic signed [1:0] DELTA_SET   = 2'sb01;
	localparam logic signed [1:0] DELTA_CLEAR = 2'sb11;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_INIT1,
		ST_INIT2,
		ST_XA1,
		ST_MA1,
		ST_XA2,
		ST_MA2,
		ST_XA3,
		ST_XB1,
		ST_MB1,
		ST_XB2,
		ST_MB2,
		ST_XB3,
		ST_SUM,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef enum logic [2:0] {
		MUL_K1,
		MUL_K2,
		MUL_FA1,
		MUL_FA2,
		MUL_FB1,
		MUL_FB2
	} mul_sel_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LL,
		PH_LH,
		PH_HL,
		PH_DONE
	} mul_ph_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_INIT1,
		OP_INIT2,
		OP_XS_A,
		OP_XS_B,
		OP_SUM,
		OP_READ,
		OP_WRITE
	} dp_op_t;

	typedef struct packed {
		dp_op_t   op;
		logic     mul_start;
		mul_sel_t mul_sel;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mul_busy;
		logic mul_done;
		logic out_free;
	} status_t;

endpackage

// File: rtl/core/xbs_mul64.sv
// Iterative 64x64 multiply modulo 2^64 over one shared 32x32 multiplier.
module xbs_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	input  logic [63:0] c,
	output logic        busy,
	output logic        done,
	output logic [63:0] product
);
	import xbs_pkg::*;

	mul_ph_t     ph_q;
	logic [63:0] x_q;
	logic [63:0] c_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] acc_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			unique case (ph_q)
				PH_IDLE: if (start) ph_q <= PH_LL;
				PH_LL:   ph_q <= PH_LH;
				PH_LH:   ph_q <= PH_HL;
				PH_HL:   ph_q <= PH_DONE;
				PH_DONE: ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	// low*low, then the two cross terms; only their low halves reach the result
	assign mul_a  = (ph_q == PH_HL) ? x_q[63:32] : x_q[31:0];
	assign mul_b  = (ph_q == PH_LH) ? c_q[63:32] : c_q[31:0];
	assign acc_hi = acc_q[63:32] + prod_q[31:0];

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			x_q <= x;
			c_q <= c;
		end
		if (ph_q == PH_LL || ph_q == PH_LH || ph_q == PH_HL) begin
			prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
		end
		if (ph_q == PH_LH) begin
			acc_q <= prod_q;
		end else if (ph_q == PH_HL) begin
			acc_q <= {acc_hi, acc_q[31:0]};
		end
	end

	assign busy    = (ph_q != PH_IDLE);
	assign done    = (ph_q == PH_DONE);
	assign product = {acc_hi, acc_q[31:0]};

endmodule

// File: rtl/core/xbs_datapath.sv
// Datapath: config registers, hash registers, 64-bit multiplier, bitmap memory, ones counter and result register.
module xbs_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [xbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [xbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [xbs_pkg::ELEM_W-1:0]       element,
	input  xbs_pkg::cmd_t                    cmd,
	output xbs_pkg::status_t                 status,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic signed [1:0]                bit_delta,
	output logic [xbs_pkg::WORD_IDX_W-1:0]   word_index,
	output logic [xbs_pkg::BIT_POS_W-1:0]    bit_position,
	output logic [xbs_pkg::COUNT_W-1:0]      ones_total
);
	import xbs_pkg::*;

	function automatic logic [BIT_POS_W-1:0] tz_capped(input logic [WORD_BITS-1:0] v);
		logic [BIT_POS_W-1:0] n;
		n = BIT_POS_W'(BIT_CAP);
		for (int i = BIT_CAP - 1; i >= 0; i--) begin
			if (v[i]) n = BIT_POS_W'(i);
		end
		return n;
	endfunction

	logic [WORD_BITS-1:0]  mem [BITMAP_WORDS];

	logic [SEED_W-1:0]     seed_q;
	logic [LOG2_W-1:0]     log2_q;
	logic [63:0]           k_q;
	logic [63:0]           a_q;
	logic [63:0]           b_q;
	logic [WORD_IDX_W-1:0] idx_q;
	logic [BIT_POS_W-1:0]  pos_q;
	logic [WORD_BITS-1:0]  rd_q;
	logic [WORD_IDX_W-1:0] clr_addr_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  out_valid_q;
	logic signed [1:0]     delta_q;
	logic [WORD_IDX_W-1:0] out_idx_q;
	logic [BIT_POS_W-1:0]  out_pos_q;

	logic [63:0]           seed64;
	logic [63:0]           mul_x;
	logic [63:0]           mul_c;
	logic [63:0]           mul_p;
	logic                  mul_busy;
	logic                  mul_done;
	logic [L2_W-1:0]       l2_eff;
	logic [WORD_IDX_W-1:0] idx_mask;
	logic [WORD_IDX_W-1:0] idx_next;
	logic [WORD_BITS-1:0]  bit_sel;
	logic                  was_set;
	logic                  out_free;
	logic                  wr_en;
	logic [WORD_IDX_W-1:0] wr_addr;
	logic [WORD_BITS-1:0]  wr_data;

	assign seed64 = {32'b0, seed_q};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_K1:  begin mul_x = k_q; mul_c = MUL_C1; end
			MUL_K2:  begin mul_x = k_q; mul_c = MUL_C2; end
			MUL_FA1: begin mul_x = a_q; mul_c = MIX_F1; end
			MUL_FA2: begin mul_x = a_q; mul_c = MIX_F2; end
			MUL_FB1: begin mul_x = b_q; mul_c = MIX_F1; end
			MUL_FB2: begin mul_x = b_q; mul_c = MIX_F2; end
			default: begin mul_x = k_q; mul_c = MUL_C1; end
		endcase
	end

	xbs_mul64 u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.x       (mul_x),
		.c       (mul_c),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_p)
	);

	// word mask: the low log2 bits set, log2 capped first; the mask is 11 bits wide
	always_comb begin
		l2_eff = (L2_W'(log2_q) > L2_W'(LOG2_CAP)) ? L2_W'(LOG2_CAP) : L2_W'(log2_q);
		for (int i = 0; i < WORD_IDX_W; i++) begin
			idx_mask[i] = (L2_W'(i) < l2_eff);
		end
	end

	assign idx_next = a_q[WORD_IDX_W-1:0] & idx_mask;
	assign bit_sel  = WORD_BITS'(1) << pos_q;
	assign was_set  = rd_q[pos_q];
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			log2_q <= WORDS_LOG2_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_HASH_SEED:  seed_q <= cfg_data[SEED_W-1:0];
				CFG_WORDS_LOG2: log2_q <= cfg_data[LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_done) begin
			unique case (cmd.mul_sel)
				MUL_K1:           k_q <= {mul_p[32:0], mul_p[63:33]};
				MUL_K2:           k_q <= mul_p;
				MUL_FA1, MUL_FA2: a_q <= mul_p;
				MUL_FB1, MUL_FB2: b_q <= mul_p;
				default: ;
			endcase
		end
		case (cmd.op)
			OP_LOAD: k_q <= {32'b0, element};
			OP_INIT1: begin
				a_q <= (seed64 ^ k_q ^ KEY_LEN) + (seed64 ^ KEY_LEN);
				b_q <= seed64 ^ KEY_LEN;
			end
			OP_INIT2: b_q <= b_q + a_q;
			OP_XS_A:  a_q <= a_q ^ (a_q >> 33);
			OP_XS_B:  b_q <= b_q ^ (b_q >> 33);
			OP_SUM:   a_q <= a_q + b_q;
			OP_READ: begin
				idx_q <= idx_next;
				pos_q <= tz_capped(a_q[63:32]);
			end
			OP_WRITE: begin
				delta_q   <= was_set ? DELTA_CLEAR : DELTA_SET;
				out_idx_q <= idx_q;
				out_pos_q <= pos_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q ^ bit_sel;
		if (cmd.op == OP_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (cmd.op == OP_WRITE) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.op == OP_READ) begin
			rd_q <= mem[idx_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.op == OP_WRITE) begin
				count_q     <= was_set ? count_q - 1'b1 : count_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.clr_last = (clr_addr_q == WORD_IDX_W'(BITMAP_WORDS - 1));
	assign status.mul_busy = mul_busy;
	assign status.mul_done = mul_done;
	assign status.out_free = out_free;

	assign out_valid    = out_valid_q;
	assign bit_delta    = delta_q;
	assign word_index   = out_idx_q;
	assign bit_position = out_pos_q;
	assign ones_total   = count_q;

endmodule

// File: rtl/core/xbs_ctrl.sv
// Controller: clearing sweep, hash step sequence and bitmap update handshake.
module xbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  xbs_pkg::status_t  status,
	output xbs_pkg::cmd_t     cmd
);
	import xbs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.op        = OP_NONE;
		cmd.mul_start = 1'b0;
		cmd.mul_sel   = MUL_K1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_K1;
				end
			end
			ST_K1: begin
				cmd.mul_sel   = MUL_K1;
				cmd.mul_start = !status.mul_busy;
				if (status.mul_done) state_d = ST_K2;
			end
			ST_K2: begin
				cmd.mul_sel   = MUL_K2;
				cmd.mul_start = !status.mul_busy;
				if (status.mul_done) state_d = ST_INIT1;
			end
			ST_INIT1: begin
				cmd.op  = OP_INIT1;
				state_d = ST_INIT2;
			end
			ST_INIT2: begin
				cmd.op  = OP_INIT2;
				state_d = ST_XA1;
			end
			ST_XA1: begin
				cmd.op  = OP_XS_A;
				state_d = ST_MA1;
			end
			ST_MA1: begin
				cmd.mul_sel   = MUL_FA1;
				cmd.mul_start = !status.mul_busy;
				if (status.mul_done) state_d = ST_XA2;
			end
			ST_XA2: begin
				cmd.op  = OP_XS_A;
				state_d = ST_MA2;
			end
			ST_MA2: begin
				cmd.mul_sel   = MUL_FA2;
				cmd.mul_start = !status.mul_busy;
				if (status.mul_done) state_d = ST_XA3;
			end
			ST_XA3: begin
				cmd.op  = OP_XS_A;
				state_d = ST_XB1;
			end
			ST_XB1: begin
				cmd.op  = OP_XS_B;
				state_d = ST_MB1;
			end
			ST_MB1: begin
				cmd.mul_sel   = MUL_FB1;
				cmd.mul_start = !status.mul_busy;
				if (status.mul_done) state_d = ST_XB2;
			end
			ST_XB2: begin
				cmd.op  = OP_XS_B;
				state_d = ST_MB2;
			end
			ST_MB2: begin
				cmd.mul_sel   = MUL_FB2;
				cmd.mul_start = !status.mul_busy;
				if (status.mul_done) state_d = ST_XB3;
			end
			ST_XB3: begin
				cmd.op  = OP_XS_B;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.op  = OP_READ;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold the read word until the result register can take the item
				if (status.out_free) begin
					cmd.op  = OP_WRITE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/core/xor_bitmap_sketch_update.sv
// One item is in work at a time: a new item is taken only after the bitmap update of the last.
// The six 64-bit hash multiplies share one 32x32 multiplier, then the bitmap word is read
// and its bit toggled; a result waits in the output register while the next item is
// hashed. After reset all 2048 bitmap words are cleared, one word a cycle, with in_ready
// low; config writes are taken during the sweep.
module xor_bitmap_sketch_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [xbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [xbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [xbs_pkg::ELEM_W-1:0]       element,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [1:0]                bit_delta,
	output logic [xbs_pkg::WORD_IDX_W-1:0]   word_index,
	output logic [xbs_pkg::BIT_POS_W-1:0]    bit_position,
	output logic [xbs_pkg::COUNT_W-1:0]      ones_total
);
	import xbs_pkg::*;

	cmd_t    cmd;
	status_t status;

	xbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	xbs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.element      (element),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.bit_delta    (bit_delta),
		.word_index   (word_index),
		.bit_position (bit_position),
		.ones_total   (ones_total)
	);

`ifndef NO_ASSERTIONS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

	a_delta_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bit_delta == DELTA_SET || bit_delta == DELTA_CLEAR))
		else $error("result delta is neither +1 nor -1");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == OP_WRITE))
		else $error("result shown without a bitmap update");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> (cmd.op == OP_NONE && !in_ready))
		else $error("multiply finished outside a multiply step");
`endif

endmodule

// File: test/tb_xor_bitmap_sketch_update.sv
// Self-checking testbench for the XOR bitmap sketch update block.
module tb_xor_bitmap_sketch_update;
	timeunit 1ns;
	timeprecision 1ps;

	import xbs_pkg::*;

	localparam int HOLD_CYCLES = 800;
	localparam int QUIET_LIMIT = 20000;
	localparam int RECENT_MAX  = 48;
	localparam int PHASE_ITEMS = 305;

	// register slots past the two defined ones; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

	localparam logic [63:0] HC1 = 64'h87c37b91114253d5;
	localparam logic [63:0] HC2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] FM1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FM2 = 64'hc4ceb9fe1a85ec53;

	typedef struct packed {
		logic signed [1:0]     delta;
		logic [WORD_IDX_W-1:0] word;
		logic [BIT_POS_W-1:0]  pos;
		logic [COUNT_W-1:0]    ones;
	} toggle_t;

	typedef struct packed {
		logic [ELEM_W-1:0]  elem;
		logic               fixed;
		logic signed [1:0]  delta;
		logic [COUNT_W-1:0] ones;
	} directed_row_t;

	// first four rows start from a cleared bitmap: each of two elements sets then clears its bit
	directed_row_t directed_rows [20] = '{
		'{32'h0000_0000, 1'b1, DELTA_SET,   17'd1},
		'{32'h0000_0000, 1'b1, DELTA_CLEAR, 17'd0},
		'{32'hFFFF_FFFF, 1'b1, DELTA_SET,   17'd1},
		'{32'hFFFF_FFFF, 1'b1, DELTA_CLEAR, 17'd0},
		'{32'h0000_0001, 1'b0, 2'sb00, 17'd0},
		'{32'h8000_0000, 1'b0, 2'sb00, 17'd0},
		'{32'h7FFF_FFFF, 1'b0, 2'sb00, 17'd0},
		'{32'hFFFF_FFFE, 1'b0, 2'sb00, 17'd0},
		'{32'h0000_FFFF, 1'b0, 2'sb00, 17'd0},
		'{32'hFFFF_0000, 1'b0, 2'sb00, 17'd0},
		'{32'hAAAA_AAAA, 1'b0, 2'sb00, 17'd0},
		'{32'h5555_5555, 1'b0, 2'sb00, 17'd0},
		'{32'h00FF_00FF, 1'b0, 2'sb00, 17'd0},
		'{32'hFF00_FF00, 1'b0, 2'sb00, 17'd0},
		'{32'h1234_5678, 1'b0, 2'sb00, 17'd0},
		'{32'h8765_4321, 1'b0, 2'sb00, 17'd0},
		'{32'h0000_0001, 1'b0, 2'sb00, 17'd0},
		'{32'hAAAA_AAAA, 1'b0, 2'sb00, 17'd0},
		'{32'h0F0F_0F0F, 1'b0, 2'sb00, 17'd0},
		'{32'hF0F0_F0F0, 1'b0, 2'sb00, 17'd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [ELEM_W-1:0]      element;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [1:0]      bit_delta;
	logic [WORD_IDX_W-1:0]  word_index;
	logic [BIT_POS_W-1:0]   bit_position;
	logic [COUNT_W-1:0]     ones_total;

	// mirror of the block state
	logic [WORD_BITS-1:0] sketch_words [BITMAP_WORDS];
	logic [COUNT_W-1:0]   sketch_ones;
	logic [SEED_W-1:0]    sketch_seed;
	logic [LOG2_W-1:0]    sketch_log2;

	toggle_t           pending_toggles [$];
	logic [ELEM_W-1:0] recent_elems [$];
	int                mismatches;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                hold_phase;
	int                quiet_cycles;

	xor_bitmap_sketch_update u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element      (element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bit_delta    (bit_delta),
		.word_index   (word_index),
		.bit_position (bit_position),
		.ones_total   (ones_total)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] fmix64(input logic [63:0] k);
		k = k ^ (k >> 33);
		k = k * FM1;
		k = k ^ (k >> 33);
		k = k * FM2;
		k = k ^ (k >> 33);
		return k;
	endfunction

	// h1 of the 128-bit x64 hash over a 4-byte key
	function automatic logic [63:0] murmur_h1(input logic [31:0] key, input logic [31:0] seed);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] k;
		a = {32'd0, seed};
		b = a;
		k = {32'd0, key};
		k = k * HC1;
		k = {k[32:0], k[63:33]};
		k = k * HC2;
		a = a ^ k;
		a = a ^ 64'd4;
		b = b ^ 64'd4;
		a = a + b;
		b = b + a;
		a = fmix64(a);
		b = fmix64(b);
		return a + b;
	endfunction

	// hash the element, flip its bit in the mirror and return the result it should produce
	function automatic toggle_t toggle_element(input logic [ELEM_W-1:0] e);
		logic [63:0] h;
		logic [31:0] lo_w;
		logic [31:0] hi_w;
		logic [31:0] mask;
		logic [WORD_IDX_W-1:0] idx;
		int pos;
		toggle_t r;
		h = murmur_h1(e, sketch_seed);
		lo_w = h[31:0];
		hi_w = h[63:32];
		// a 4-bit register never exceeds the log2 cap of 16
		mask = 32'((64'd1 << sketch_log2) - 64'd1);
		idx = WORD_IDX_W'((lo_w & mask) % BITMAP_WORDS);
		pos = 0;
		while (pos < BIT_CAP && hi_w[pos] == 1'b0)
			pos++;
		if (sketch_words[idx][pos]) begin
			sketch_ones = sketch_ones - 1'b1;
			r.delta = DELTA_CLEAR;
		end else begin
			sketch_ones = sketch_ones + 1'b1;
			r.delta = DELTA_SET;
		end
		sketch_words[idx][pos] = ~sketch_words[idx][pos];
		r.word = idx;
		r.pos = BIT_POS_W'(pos);
		r.ones = sketch_ones;
		return r;
	endfunction

	function automatic logic [ELEM_W-1:0] pick_element();
		int roll;
		logic [ELEM_W-1:0] e;
		roll = $urandom_range(99);
		if (roll < 45 && recent_elems.size() > 0) begin
			// replay a recent element so its bit flips back
			e = recent_elems[$urandom_range(recent_elems.size() - 1)];
		end else if (roll < 55) begin
			e = 32'd1 << $urandom_range(31);
			if ($urandom_range(1) == 1)
				e = ~e;
		end else begin
			e = $urandom;
		end
		return e;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_HASH_SEED: begin
				sketch_seed = data;
			end
			CFG_WORDS_LOG2: begin
				sketch_log2 = data[LOG2_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// hold the item until the block takes it, then predict its result
	task automatic offer_element(input logic [ELEM_W-1:0] e, output toggle_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		element <= e;
		do
			@(posedge clk);
		while (!in_ready);
		want = toggle_element(e);
		recent_elems.insert(recent_elems.size(), e);
		if (recent_elems.size() > RECENT_MAX)
			void'(recent_elems.pop_front());
	endtask

	task automatic wait_drained();
		while (pending_toggles.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [SEED_W-1:0] seed, input logic [LOG2_W-1:0] l2,
			input int send_pct, input int recv_pct, input bit squeeze, input int count);
		toggle_t want;
		wait_drained();
		write_reg(CFG_HASH_SEED, seed);
		write_reg(CFG_WORDS_LOG2, ($urandom & 32'hFFFF_FFF0) | 32'(l2));
		write_reg(CFG_SPARE2, $urandom);
		write_reg(CFG_SPARE3, $urandom);
		cfg_write <= 1'b0;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (squeeze)
			hold_phase <= hold_phase + 1;
		for (int i = 0; i < count; i++) begin
			offer_element(pick_element(), want);
			pending_toggles.insert(pending_toggles.size(), want);
		end
		in_valid <= 1'b0;
	endtask

	task automatic check_result();
		toggle_t want;
		if (pending_toggles.size() == 0) begin
			$error("unexpected result: delta %0d word %0d bit %0d ones %0d",
				bit_delta, word_index, bit_position, ones_total);
			mismatches++;
			return;
		end
		want = pending_toggles.pop_front();
		if (bit_delta !== want.delta) begin
			$error("bit_delta: expected %0d, got %0d", want.delta, bit_delta);
			mismatches++;
		end
		if (word_index !== want.word) begin
			$error("word_index: expected %0d, got %0d", want.word, word_index);
			mismatches++;
		end
		if (bit_position !== want.pos) begin
			$error("bit_position: expected %0d, got %0d", want.pos, bit_position);
			mismatches++;
		end
		if (ones_total !== want.ones) begin
			$error("ones_total: expected %0d, got %0d", want.ones, ones_total);
			mismatches++;
		end
	endtask

	// result side: check every accepted result and drive out_ready
	initial begin : result_side
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_result();
			if (hold_phase != served) begin
				served = hold_phase;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL xor_bitmap_sketch_update");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		toggle_t want;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_HASH_SEED;
		cfg_data = '0;
		in_valid = 1'b0;
		element = '0;
		out_ready = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_phase = 0;
		quiet_cycles = 0;
		sketch_ones = '0;
		sketch_seed = '0;
		sketch_log2 = WORDS_LOG2_RESET;
		for (int w = 0; w < BITMAP_WORDS; w++)
			sketch_words[w] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows run on the reset configuration
		foreach (directed_rows[i]) begin
			offer_element(directed_rows[i].elem, want);
			if (directed_rows[i].fixed) begin
				want.delta = directed_rows[i].delta;
				want.ones = directed_rows[i].ones;
			end
			pending_toggles.insert(pending_toggles.size(), want);
		end
		in_valid <= 1'b0;

		// one word in use, then index wrap at 15 and 12, then a long output stall, then random log2, then a mixed phase
		run_phase(32'hFFFF_FFFF, 4'd0, 0, 0, 1'b0, PHASE_ITEMS);
		run_phase($urandom, 4'd15, 75, 0, 1'b0, PHASE_ITEMS);
		run_phase(32'h0000_0000, 4'd12, 0, 75, 1'b0, PHASE_ITEMS);
		run_phase($urandom, 4'd11, 11, 11, 1'b1, PHASE_ITEMS);
		run_phase($urandom, LOG2_W'($urandom_range(15)), 0, 0, 1'b0, PHASE_ITEMS);
		run_phase($urandom, 4'd11, 11, 11, 1'b0, PHASE_ITEMS);

		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("PASS xor_bitmap_sketch_update");
		else
			$display("FAIL xor_bitmap_sketch_update");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/xbs_pkg.sv
rtl/core/xbs_mul64.sv
rtl/core/xbs_datapath.sv
rtl/core/xbs_ctrl.sv
rtl/core/xor_bitmap_sketch_update.sv
test/tb_xor_bitmap_sketch_update.sv
